### hdl/cesd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cesd_pkg: shared types, character codes and helpers
// Types and functions used by the escape decoder, its result buffer and top.
// ----------------------------------------------------------------------------
package cesd_pkg;

	localparam int UnitW = 32;
	localparam int MaxRes = 4;
	localparam int AddrW = 3;

	// register byte addresses (bit 2 upward selects the word)
	localparam logic [AddrW-1:0] REG_WIDE_MODE = 3'd0;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LC_U   = 8'h75;
	localparam logic [7:0] CH_UC_U   = 8'h55;
	localparam logic [7:0] CH_LC_X   = 8'h78;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_V   = 8'h76;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	localparam logic [3:0] UNI_SHORT_DIGITS = 4'd4;
	localparam logic [3:0] UNI_LONG_DIGITS  = 4'd8;

	typedef enum logic [4:0] {
		PH_NORMAL = 5'b00001,
		PH_ESCAPE = 5'b00010,
		PH_HEX    = 5'b00100,
		PH_OCT    = 5'b01000,
		PH_UNI    = 5'b10000
	} phase_t;

	typedef logic [MaxRes-1:0][UnitW-1:0] unit_vec_t;

	// words produced by one byte; vals[0] goes out first
	typedef struct packed {
		logic [2:0] cnt;
		unit_vec_t  vals;
		logic       last;
		logic       err;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t h;
		h.ok = 1'b1;
		h.val = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h.val = b[3:0];
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			h.val = b[3:0] + 4'd9;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic logic is_dec(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39);
	endfunction

	// universal character: one full unit in wide mode, else 1 to 4 UTF-8 bytes
	function automatic res_t uni_encode(input logic [31:0] v, input logic wide);
		res_t r;
		r = '0;
		if (wide || v <= 32'h7F) begin
			r.cnt = 3'd1;
			r.vals[0] = v;
		end else if (v <= 32'h7FF) begin
			r.cnt = 3'd2;
			r.vals[0] = {24'h0, 8'hC0 | {3'b0, v[10:6]}};
			r.vals[1] = {24'h0, 2'b10, v[5:0]};
		end else if (v <= 32'hFFFF) begin
			r.cnt = 3'd3;
			r.vals[0] = {24'h0, 8'hE0 | {4'b0, v[15:12]}};
			r.vals[1] = {24'h0, 2'b10, v[11:6]};
			r.vals[2] = {24'h0, 2'b10, v[5:0]};
		end else begin
			r.cnt = 3'd4;
			r.vals[0] = {24'h0, 8'hF0 | v[25:18]};
			r.vals[1] = {24'h0, 2'b10, v[17:12]};
			r.vals[2] = {24'h0, 2'b10, v[11:6]};
			r.vals[3] = {24'h0, 2'b10, v[5:0]};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/cesd_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cesd_decode: escape parser
// Next parse state and the result words for one registered source byte.
// ----------------------------------------------------------------------------
module cesd_decode (
	input  wire logic              [7:0]  byte_i,
	input  wire logic                     eos,
	input  wire logic                     wide,
	input  wire cesd_pkg::phase_t         phase,
	input  wire logic              [31:0] acc,
	input  wire logic              [3:0]  digits,
	output cesd_pkg::phase_t              phase_nxt,
	output logic                   [31:0] acc_nxt,
	output logic                   [3:0]  digits_nxt,
	output cesd_pkg::res_t                res
);
	import cesd_pkg::*;

	hex_t       hx;
	logic       dec;
	logic [3:0] dig_dec;

	assign hx = hex_decode(byte_i);
	assign dec = is_dec(byte_i);
	assign dig_dec = digits - 4'd1;

	always_comb begin
		phase_t     ph;
		logic [31:0] a;
		logic [3:0]  d;
		res_t        r;
		logic        plain;
		logic [31:0] unit;
		ph = phase;
		a = acc;
		d = digits;
		r = '0;
		plain = 1'b0;
		unit = wide ? acc : {24'h0, acc[7:0]};
		case (phase)
			PH_ESCAPE: begin
				ph = PH_NORMAL;
				a = '0;
				r.cnt = 3'd1;
				case (byte_i)
					CH_LC_N: r.vals[0] = 32'h0A;
					CH_LC_T: r.vals[0] = 32'h09;
					CH_LC_V: r.vals[0] = 32'h0B;
					CH_LC_B: r.vals[0] = 32'h08;
					CH_LC_R: r.vals[0] = 32'h0D;
					CH_LC_F: r.vals[0] = 32'h0C;
					CH_LC_A: r.vals[0] = 32'h07;
					CH_LC_X: begin
						ph = PH_HEX;
						r.cnt = 3'd0;
					end
					CH_LC_U: begin
						ph = PH_UNI;
						d = UNI_SHORT_DIGITS;
						r.cnt = 3'd0;
					end
					CH_UC_U: begin
						ph = PH_UNI;
						d = UNI_LONG_DIGITS;
						r.cnt = 3'd0;
					end
					default: begin
						if (dec) begin
							ph = PH_OCT;
							a = {28'h0, byte_i[3:0]};
							r.cnt = 3'd0;
						end else begin
							r.vals[0] = {24'h0, byte_i};
						end
					end
				endcase
			end
			PH_HEX: begin
				if (hx.ok) begin
					a = {acc[27:0], hx.val};
				end else begin
					r.cnt = 3'd1;
					r.vals[0] = unit;
					ph = PH_NORMAL;
					plain = 1'b1;
				end
			end
			PH_OCT: begin
				if (dec) begin
					a = {acc[28:0], 3'b000} | {28'h0, byte_i[3:0]};
				end else begin
					r.cnt = 3'd1;
					r.vals[0] = unit;
					ph = PH_NORMAL;
					plain = 1'b1;
				end
			end
			PH_UNI: begin
				a = {acc[27:0], hx.ok ? hx.val : 4'd0};
				d = dig_dec;
				if (dig_dec == 4'd0) begin
					r = uni_encode(a, wide);
					ph = PH_NORMAL;
				end
			end
			default: begin
				ph = PH_NORMAL;
				plain = 1'b1;
			end
		endcase

		// terminator byte of a run, or a byte in the normal phase; at most one
		// word is already queued here, so it lands in slot cnt[0]
		if (plain) begin
			if (byte_i == CH_BSLASH) begin
				if (eos) begin
					r.vals[{1'b0, r.cnt[0]}] = '0;
					r.err = 1'b1;
					r.cnt = r.cnt + 3'd1;
				end else begin
					ph = PH_ESCAPE;
				end
			end else begin
				r.vals[{1'b0, r.cnt[0]}] = {24'h0, byte_i};
				r.cnt = r.cnt + 3'd1;
			end
		end

		// end of string flushes an open run; nothing is queued in those phases
		if (eos) begin
			if (ph == PH_HEX || ph == PH_OCT) begin
				r.cnt = 3'd1;
				r.vals[0] = wide ? a : {24'h0, a[7:0]};
			end else if (ph == PH_UNI) begin
				r = uni_encode(a, wide);
			end
			r.last = (r.cnt != 3'd0);
			ph = PH_NORMAL;
			a = '0;
			d = '0;
		end

		phase_nxt = ph;
		acc_nxt = a;
		digits_nxt = d;
		res = r;
	end

endmodule
`default_nettype wire

### hdl/cesd_outbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cesd_outbuf: result register
// Holds one byte's words and hands out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module cesd_outbuf (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  wire cesd_pkg::res_t res,
	output logic                free,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic         [31:0] out_value,
	output logic                out_last,
	output logic                out_error
);
	import cesd_pkg::*;

	logic [2:0] rem_q;
	unit_vec_t  vals_q;
	logic       last_q;
	logic       err_q;

	assign out_valid = (rem_q != 3'd0);
	assign free = (rem_q == 3'd0) || (rem_q == 3'd1 && out_ready);
	assign out_value = vals_q[0];
	// flags belong to the final word of the group
	assign out_last = last_q && (rem_q == 3'd1);
	assign out_error = err_q && (rem_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= res.cnt;
		end else if (out_valid && out_ready) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			vals_q <= res.vals;
			last_q <= res.last;
			err_q <= res.err;
		end else if (out_valid && out_ready) begin
			vals_q <= {{UnitW{1'b0}}, vals_q[MaxRes-1:1]};
		end
	end

endmodule
`default_nettype wire

### hdl/c_escape_sequence_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder: C string literal unescaper
// Decodes escapes of a literal body, one source byte in, decoded units out.
// ----------------------------------------------------------------------------
//  channel | signals                                     | direction
//  in      | in_valid/in_ready, in_byte, end_of_string   | source bytes
//  out     | out_valid/out_ready, out_value, out_last/err| decoded words
//  cfg     | APB psel..prdata, bit 0 of word 0 = wide    | register access
//
// A byte is decoded in the cycle after it is taken; its decoded words then go
// out one per cycle while out_ready is high, so the rate is one byte per cycle
// except when a byte yields two to four words (UTF-8 output, run terminator).
// The result register gates the input register: a byte waits there while
// earlier words are drained. Reset clears parse state and wide mode.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                    [7:0]  in_byte,
	input  wire logic                           end_of_string,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                         [31:0] out_value,
	output logic                                out_last,
	output logic                                out_error,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [cesd_pkg::AddrW-1:0]     paddr,
	input  wire logic                    [31:0] pwdata,
	output logic                         [31:0] prdata,
	output logic                                pready
);
	import cesd_pkg::*;

	logic       wide_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	phase_t     phase_q;
	logic [31:0] acc_q;
	logic [3:0] digits_q;

	phase_t     phase_nxt;
	logic [31:0] acc_nxt;
	logic [3:0] digits_nxt;
	res_t       res;
	logic       buf_free;
	logic       advance;
	logic       reg_sel;

	// config port
	assign pready = 1'b1;
	assign reg_sel = (paddr[AddrW-1:2] == REG_WIDE_MODE[AddrW-1:2]);
	assign prdata = reg_sel ? {31'h0, wide_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			wide_q <= pwdata[0];
		end
	end

	// input register
	assign advance = valid_s1 && (res.cnt == 3'd0 || buf_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			eos_s1 <= end_of_string;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			acc_q <= '0;
			digits_q <= '0;
		end else if (advance) begin
			phase_q <= phase_nxt;
			acc_q <= acc_nxt;
			digits_q <= digits_nxt;
		end
	end

	cesd_decode u_decode (
		.byte_i     (byte_s1),
		.eos        (eos_s1),
		.wide       (wide_q),
		.phase      (phase_q),
		.acc        (acc_q),
		.digits     (digits_q),
		.phase_nxt  (phase_nxt),
		.acc_nxt    (acc_nxt),
		.digits_nxt (digits_nxt),
		.res        (res)
	);

	cesd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res.cnt != 3'd0),
		.res       (res),
		.free      (buf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_value (out_value),
		.out_last  (out_last),
		.out_error (out_error)
	);

endmodule
`default_nettype wire

### hdl/cesd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cesd_checker: port-level checks
// Watches the top level ports; attached by the bind below.
// ----------------------------------------------------------------------------
module cesd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] out_value,
	input wire logic        out_last,
	input wire logic        out_error
);

	// an error word always closes the string
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_error |-> out_last)
		else $error("error word without last");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_error |-> out_value == 32'h0)
		else $error("error word with nonzero value");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value)
			&& $stable(out_last) && $stable(out_error))
		else $error("stalled word changed");

endmodule

bind c_escape_sequence_decoder cesd_checker u_cesd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_value (out_value),
	.out_last  (out_last),
	.out_error (out_error)
);
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for c_escape_sequence_decoder
// Streams literal bodies (plain text, simple, hex, octal and universal escapes,
// broken tails) in narrow and wide mode and checks every decoded word in order.
// ----------------------------------------------------------------------------
module tb;
	import cesd_pkg::*;

	typedef logic [7:0] char_t;

	typedef struct packed {
		logic [31:0] value;
		logic        last;
		logic        err;
	} unit_t;

	localparam char_t CH_NINE   = 8'h39;
	localparam char_t CH_UC_A   = 8'h41;
	localparam char_t CH_UC_F   = 8'h46;
	localparam char_t CH_DQUOTE = 8'h22;
	localparam char_t CH_SQUOTE = 8'h27;
	localparam int WATCHDOG_LIMIT = 1000;

	// Tracks the decoder state and holds the words each source byte owes.
	class unescape_tracker;
		logic        wide;
		phase_t      phase;
		logic [31:0] acc;
		logic [3:0]  left;
		logic        uni_long;
		unit_t       owed_units[$];
		int          errors;
		int          bytes_seen;
		int          units_seen;

		function new();
			wide = 1'b0;
			phase = PH_NORMAL;
			acc = '0;
			left = '0;
			uni_long = 1'b0;
			errors = 0;
			bytes_seen = 0;
			units_seen = 0;
		endfunction

		function bit is_decimal(char_t b);
			return b >= CH_ZERO && b <= CH_NINE;
		endfunction

		function int nibble_of(char_t b);
			if (is_decimal(b))
				return b - CH_ZERO;
			if (b >= CH_LC_A && b <= CH_LC_F)
				return b - CH_LC_A + 10;
			if (b >= CH_UC_A && b <= CH_UC_F)
				return b - CH_UC_A + 10;
			return -1;
		endfunction

		function void push(logic [31:0] v, logic err);
			unit_t u;
			u.value = v;
			u.last = 1'b0;
			u.err = err;
			owed_units.insert(owed_units.size(), u);
		endfunction

		function void push_unit(logic [31:0] v);
			push(wide ? v : {24'h0, v[7:0]}, 1'b0);
		endfunction

		function void push_universal(logic [31:0] v);
			if (wide || v <= 32'h7F) begin
				push(v, 1'b0);
			end else if (v <= 32'h7FF) begin
				push(32'hC0 | (v >> 6), 1'b0);
				push(32'h80 | (v & 32'h3F), 1'b0);
			end else if (v <= 32'hFFFF) begin
				push(32'hE0 | (v >> 12), 1'b0);
				push(32'h80 | ((v >> 6) & 32'h3F), 1'b0);
				push(32'h80 | (v & 32'h3F), 1'b0);
			end else begin
				// lead byte keeps only 8 bits of the oversized prefix
				push((32'hF0 | (v >> 18)) & 32'hFF, 1'b0);
				push(32'h80 | ((v >> 12) & 32'h3F), 1'b0);
				push(32'h80 | ((v >> 6) & 32'h3F), 1'b0);
				push(32'h80 | (v & 32'h3F), 1'b0);
			end
		endfunction

		function void plain_char(char_t b, logic eos);
			if (b == CH_BSLASH) begin
				if (eos)
					push(32'h0, 1'b1);
				else
					phase = PH_ESCAPE;
			end else begin
				push({24'h0, b}, 1'b0);
			end
		endfunction

		function void escape_char(char_t b);
			phase = PH_NORMAL;
			acc = '0;
			case (b)
				CH_LC_N: push(32'h0A, 1'b0);
				CH_LC_T: push(32'h09, 1'b0);
				CH_LC_V: push(32'h0B, 1'b0);
				CH_LC_B: push(32'h08, 1'b0);
				CH_LC_R: push(32'h0D, 1'b0);
				CH_LC_F: push(32'h0C, 1'b0);
				CH_LC_A: push(32'h07, 1'b0);
				CH_LC_X: phase = PH_HEX;
				CH_LC_U: begin
					phase = PH_UNI;
					left = UNI_SHORT_DIGITS;
					uni_long = 1'b0;
				end
				CH_UC_U: begin
					phase = PH_UNI;
					left = UNI_LONG_DIGITS;
					uni_long = 1'b1;
				end
				default: begin
					if (is_decimal(b)) begin
						phase = PH_OCT;
						acc = 32'(b - CH_ZERO);
					end else begin
						push({24'h0, b}, 1'b0);
					end
				end
			endcase
		endfunction

		function void take_byte(char_t b, logic eos);
			int n0;
			int h;
			n0 = owed_units.size();
			h = nibble_of(b);
			bytes_seen++;
			case (phase)
				PH_ESCAPE: escape_char(b);
				PH_HEX: begin
					if (h >= 0) begin
						acc = (acc << 4) | 32'(h);
					end else begin
						push_unit(acc);
						phase = PH_NORMAL;
						plain_char(b, eos);
					end
				end
				PH_OCT: begin
					// 8 and 9 are shifted in by 3 bits as written
					if (is_decimal(b)) begin
						acc = (acc << 3) | 32'(b - CH_ZERO);
					end else begin
						push_unit(acc);
						phase = PH_NORMAL;
						plain_char(b, eos);
					end
				end
				PH_UNI: begin
					acc = (acc << 4) | (h >= 0 ? 32'(h) : 32'h0);
					left = left - 4'd1;
					if (left == 4'd0) begin
						push_universal(acc);
						phase = PH_NORMAL;
					end
				end
				default: begin
					phase = PH_NORMAL;
					plain_char(b, eos);
				end
			endcase
			if (eos) begin
				if (phase == PH_HEX || phase == PH_OCT)
					push_unit(acc);
				else if (phase == PH_UNI)
					push_universal(acc);
				if (owed_units.size() > n0)
					owed_units[owed_units.size() - 1].last = 1'b1;
				phase = PH_NORMAL;
				acc = '0;
				left = '0;
				uni_long = 1'b0;
			end
		endfunction

		function void check_unit(logic [31:0] v, logic last, logic err);
			unit_t e;
			units_seen++;
			if (owed_units.size() == 0) begin
				$error("unexpected word: value %h last %b error %b", v, last, err);
				errors++;
				return;
			end
			e = owed_units.pop_front();
			if (v !== e.value) begin
				$error("out_value: expected %h, got %h", e.value, v);
				errors++;
			end
			if (last !== e.last) begin
				$error("out_last: expected %b, got %b", e.last, last);
				errors++;
			end
			if (err !== e.err) begin
				$error("out_error: expected %b, got %b", e.err, err);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        end_of_string;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] out_value;
	logic        out_last;
	logic        out_error;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [AddrW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	unescape_tracker sb = new();
	char_t lit[$];
	bit    calm;
	int    bytes_sent;
	int    literals_sent;
	int    idle_cycles;

	c_escape_sequence_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.end_of_string(end_of_string),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_value(out_value),
		.out_last(out_last),
		.out_error(out_error),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if (out_valid && out_ready)
				sb.check_unit(out_value, out_last, out_error);
			if (in_valid && in_ready)
				sb.take_byte(in_byte, end_of_string);
			if ((out_valid && out_ready) || (in_valid && in_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("c_escape_sequence_decoder: mismatch");
		$finish;
	end

	// receiver: ready windows broken by stall bursts, none once calm
	initial begin
		out_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
		end
	end

	function automatic void add_char(char_t c);
		lit.insert(lit.size(), c);
	endfunction

	function automatic char_t hex_char(logic [3:0] h, bit upper);
		if (h < 4'd10)
			return CH_ZERO + h;
		return (upper ? CH_UC_A : CH_LC_A) + h - 4'd10;
	endfunction

	function automatic char_t plain_char();
		char_t b;
		do
			b = char_t'($urandom_range(0, 255));
		while (b == CH_BSLASH);
		return b;
	endfunction

	function automatic char_t simple_escape(int k);
		case (k)
			0: return CH_LC_N;
			1: return CH_LC_T;
			2: return CH_LC_V;
			3: return CH_LC_B;
			4: return CH_LC_R;
			5: return CH_LC_F;
			6: return CH_LC_A;
			7: return CH_BSLASH;
			8: return CH_DQUOTE;
			default: return CH_SQUOTE;
		endcase
	endfunction

	// \u or \U with a code point from a UTF-8 length class or, for \U, any 32 bits
	function automatic void add_universal(bit long_form);
		logic [31:0] v;
		int nd;
		char_t c;
		nd = long_form ? 8 : 4;
		if (!long_form) begin
			case ($urandom_range(0, 2))
				0: v = $urandom_range(0, 32'h7F);
				1: v = $urandom_range(32'h80, 32'h7FF);
				default: v = $urandom_range(32'h800, 32'hFFFF);
			endcase
		end else begin
			case ($urandom_range(0, 3))
				0: v = $urandom_range(0, 32'h7F);
				1: v = $urandom_range(0, 32'hFFFF);
				2: v = $urandom_range(32'h10000, 32'h10FFFF);
				default: v = $urandom;
			endcase
		end
		add_char(CH_BSLASH);
		add_char(long_form ? CH_UC_U : CH_LC_U);
		for (int k = nd - 1; k >= 0; k--) begin
			c = hex_char(v[4*k +: 4], 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 15) == 0)
				c = char_t'($urandom_range(0, 255));
			add_char(c);
		end
	endfunction

	function automatic void fill_literal();
		lit.delete();
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 9))
				0, 1, 9: repeat ($urandom_range(1, 4)) add_char(plain_char());
				2: begin
					add_char(CH_BSLASH);
					add_char(simple_escape($urandom_range(0, 9)));
				end
				3: begin
					add_char(CH_BSLASH);
					add_char(char_t'($urandom_range(0, 255)));
				end
				4: begin
					add_char(CH_BSLASH);
					add_char(CH_LC_X);
					repeat ($urandom_range(0, 10))
						add_char(hex_char(4'($urandom_range(0, 15)),
							1'($urandom_range(0, 1))));
				end
				5: begin
					add_char(CH_BSLASH);
					repeat ($urandom_range(1, 12))
						add_char(CH_ZERO + char_t'($urandom_range(0, 9)));
				end
				6: add_universal(1'b0);
				7: add_universal(1'b1);
				default: add_char(char_t'($urandom_range(0, 255)));
			endcase
		end
		// broken tails: lone backslash, or a universal cut short by the end
		case ($urandom_range(0, 9))
			0: add_char(CH_BSLASH);
			1: begin
				add_char(CH_BSLASH);
				if ($urandom_range(0, 1)) begin
					add_char(CH_LC_U);
					repeat ($urandom_range(0, 3))
						add_char(hex_char(4'($urandom_range(0, 15)), 1'b0));
				end else begin
					add_char(CH_UC_U);
					repeat ($urandom_range(0, 7))
						add_char(hex_char(4'($urandom_range(0, 15)), 1'b1));
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_word(char_t b, logic eos);
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_string <= eos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_literal();
		bit gappy;
		gappy = $urandom_range(0, 2) != 0;
		foreach (lit[i]) begin
			if (!calm && gappy && $urandom_range(0, 3) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			send_word(lit[i], i == lit.size() - 1);
		end
		literals_sent++;
	endtask

	task automatic run_random(int n);
		int stop;
		stop = bytes_sent + n;
		while (bytes_sent < stop) begin
			fill_literal();
			send_literal();
		end
	endtask

	// lets the scoreboard note the last accepted byte before waiting for the drain
	task automatic wait_for_words();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.owed_units.size() != 0) @(posedge clk);
	endtask

	// mode change only with nothing in flight
	task automatic set_wide_mode(logic wide);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.owed_units.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_WIDE_MODE;
		pwdata <= {31'h0, wide};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.wide = wide;
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_byte <= 8'h00;
		end_of_string <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		calm = 1'b0;
		bytes_sent = 0;
		literals_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hex run cut by a new escape, with byte extremes up front
		lit = '{8'h00, 8'hFF, CH_BSLASH, CH_LC_X, 8'h34, 8'h31, CH_BSLASH, 8'h71};
		send_literal();
		// empty hex run
		lit = '{CH_BSLASH, CH_LC_X, 8'h47};
		send_literal();
		// decimal run with a 9, closed by the end
		lit = '{CH_BSLASH, 8'h37, 8'h39, 8'h37};
		send_literal();
		// code point above 0xFFFF in narrow mode
		lit = '{CH_BSLASH, CH_UC_U, 8'h30, 8'h30, 8'h30, 8'h31, 8'h46, 8'h36, 8'h30, 8'h30};
		send_literal();
		// short \u holding a non-hex byte
		lit = '{CH_BSLASH, CH_LC_U, 8'h7A, 8'h31};
		send_literal();
		// trailing backslash
		lit = '{CH_BSLASH};
		send_literal();

		set_wide_mode(1'b0);
		run_random(80);
		set_wide_mode(1'b1);
		run_random(45);
		wait_for_words();
		run_random(45);
		set_wide_mode(1'b0);
		calm = 1'b1;
		run_random(70);

		wait_for_words();
		repeat (20) @(posedge clk);

		$display("%0d source bytes in %0d literals, %0d words checked", sb.bytes_seen,
			literals_sent, sb.units_seen);
		$display("narrow and wide mode, all escape kinds, truncated tails, stalls both sides");
		if (sb.errors == 0)
			$display("c_escape_sequence_decoder: match");
		else
			$display("c_escape_sequence_decoder: mismatch");
		$finish;
	end

endmodule

### c_escape_sequence_decoder.f
hdl/cesd_pkg.sv
hdl/cesd_decode.sv
hdl/cesd_outbuf.sv
hdl/c_escape_sequence_decoder.sv
hdl/cesd_checker.sv
verif/tb.sv
